// File: design/mcv_pkg.sv
// Shared constants, types and the CRC-32 byte update for the message validator.
`default_nettype none

package mcv_pkg;

    // Field widths of the message words.
    localparam int SIZE_BITS = 24;
    localparam int VER_W     = 8;
    localparam int TYPE_W    = 8;
    localparam int LEN_W     = 24;
    localparam int CRC_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int ERR_W     = 3;
    localparam int CMP_W     = (SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_EXP_VERSION  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNKNOWN_TYPE = 2'd2;

    localparam logic [VER_W-1:0]  RST_EXP_VERSION  = 8'd1;
    localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD  = 24'hFFFFFF;
    localparam logic [TYPE_W-1:0] RST_UNKNOWN_TYPE = 8'd0;

    // Reflected CRC-32 constants.
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

    // Saturation value of the payload byte counter.
    localparam logic [SIZE_BITS-1:0] CNT_MAX = {SIZE_BITS{1'b1}};

    // Verdict codes, first failing check wins.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_VERSION  = 3'd1,
        ERR_OVERSIZE = 3'd2,
        ERR_TYPE     = 3'd3,
        ERR_LENGTH   = 3'd4,
        ERR_CRC      = 3'd5
    } t_err;

    typedef struct packed {
        logic [VER_W-1:0]  expected_version;
        logic [LEN_W-1:0]  max_payload_bytes;
        logic [TYPE_W-1:0] unknown_type_code;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [VER_W-1:0]  msg_version;
        logic [TYPE_W-1:0] msg_type;
        logic [LEN_W-1:0]  declared_size;
        logic [CRC_W-1:0]  stored_checksum;
        logic              no_payload;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic             valid_res;
        logic [ERR_W-1:0] reason_code;
        logic             checksum_ok;
        logic [CRC_W-1:0] computed_crc;
    } t_res;

    // One byte of the reflected CRC-32, a shallow XOR network.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/mcv_in_if.sv
// Input channel: one header or payload word per handshake.
`default_nettype none

interface mcv_in_if;
    import mcv_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [VER_W-1:0]  msg_version;
    logic [TYPE_W-1:0] msg_type;
    logic [LEN_W-1:0]  declared_size;
    logic [CRC_W-1:0]  stored_checksum;
    logic              no_payload;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (
        output valid, kind, msg_version, msg_type, declared_size,
               stored_checksum, no_payload, data_byte, last,
        input  ready
    );

    modport sink (
        input  valid, kind, msg_version, msg_type, declared_size,
               stored_checksum, no_payload, data_byte, last,
        output ready
    );
endinterface

`default_nettype wire

// File: design/mcv_res_if.sv
// Result channel: one verdict word per handshake.
`default_nettype none

interface mcv_res_if;
    import mcv_pkg::*;

    logic             valid;
    logic             ready;
    logic             valid_res;
    logic [ERR_W-1:0] reason_code;
    logic             checksum_ok;
    logic [CRC_W-1:0] computed_crc;

    modport source (
        output valid, valid_res, reason_code, checksum_ok, computed_crc,
        input  ready
    );

    modport sink (
        input  valid, valid_res, reason_code, checksum_ok, computed_crc,
        output ready
    );
endinterface

`default_nettype wire

// File: design/mcv_cfg_regs.sv
// Configuration registers of the message validator.
`default_nettype none

module mcv_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mcv_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [mcv_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output mcv_pkg::t_cfg                       o_cfg
);
    import mcv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; indexes past the list are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_EXP_VERSION:  n_cfg.expected_version  = i_cfg_wdata[VER_W-1:0];
                REG_MAX_PAYLOAD:  n_cfg.max_payload_bytes = i_cfg_wdata[LEN_W-1:0];
                REG_UNKNOWN_TYPE: n_cfg.unknown_type_code = i_cfg_wdata[TYPE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version  <= RST_EXP_VERSION;
            r_cfg.max_payload_bytes <= RST_MAX_PAYLOAD;
            r_cfg.unknown_type_code <= RST_UNKNOWN_TYPE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/mcv_check.sv
// Input register, message state, CRC update and verdict logic.
`default_nettype none

module mcv_check (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire mcv_pkg::t_cfg i_cfg,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire mcv_pkg::t_in_word i_word,
    input  wire logic     i_res_free,
    output logic          o_res_load,
    output mcv_pkg::t_res o_res
);
    import mcv_pkg::*;

    // Input register.
    logic     r_in_valid;
    t_in_word r_word;

    // Message state.
    logic [CRC_W-1:0]     r_crc;
    logic [SIZE_BITS-1:0] r_cnt;
    logic [VER_W-1:0]     r_hdr_ver;
    logic [TYPE_W-1:0]    r_hdr_type;
    logic [LEN_W-1:0]     r_hdr_size;
    logic [CRC_W-1:0]     r_hdr_chk;

    logic [CRC_W-1:0]     n_crc;
    logic [SIZE_BITS-1:0] n_cnt;
    logic [VER_W-1:0]     n_hdr_ver;
    logic [TYPE_W-1:0]    n_hdr_type;
    logic [LEN_W-1:0]     n_hdr_size;
    logic [CRC_W-1:0]     n_hdr_chk;

    logic                 emits;
    logic                 advance;
    logic                 empty;
    logic [CRC_W-1:0]     crc_out;
    t_err                 err;

    // Values after this word: a header restarts the message, a byte extends it.
    always_comb begin
        if (!r_word.kind) begin
            n_hdr_ver  = r_word.msg_version;
            n_hdr_type = r_word.msg_type;
            n_hdr_size = r_word.declared_size;
            n_hdr_chk  = r_word.stored_checksum;
            n_crc      = CRC_ONES;
            n_cnt      = '0;
            emits      = r_word.no_payload;
        end else begin
            n_hdr_ver  = r_hdr_ver;
            n_hdr_type = r_hdr_type;
            n_hdr_size = r_hdr_size;
            n_hdr_chk  = r_hdr_chk;
            n_crc      = crc_byte(r_crc, r_word.data_byte);
            n_cnt      = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
            emits      = r_word.last;
        end
    end

    // Verdict, checked in priority order.
    always_comb begin
        empty   = (n_cnt == '0);
        crc_out = empty ? '0 : (n_crc ^ CRC_ONES);
        if (n_hdr_ver != i_cfg.expected_version) begin
            err = ERR_VERSION;
        end else if (n_hdr_size > i_cfg.max_payload_bytes) begin
            err = ERR_OVERSIZE;
        end else if (n_hdr_type == i_cfg.unknown_type_code) begin
            err = ERR_TYPE;
        end else if (CMP_W'(n_hdr_size) != CMP_W'(n_cnt)) begin
            err = ERR_LENGTH;
        end else if (!empty && (n_hdr_chk != '0) && (crc_out != n_hdr_chk)) begin
            err = ERR_CRC;
        end else begin
            err = ERR_OK;
        end
        o_res.valid_res    = (err == ERR_OK);
        o_res.reason_code  = err;
        o_res.checksum_ok  = empty ? (n_hdr_chk == '0) : (crc_out == n_hdr_chk);
        o_res.computed_crc = crc_out;
    end

    // A word leaves the input register unless its verdict has nowhere to go.
    assign advance    = r_in_valid && (!emits || i_res_free);
    assign o_in_ready = !r_in_valid || advance;
    assign o_res_load = advance && emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word <= i_word;
        end
    end

    // State update; a verdict returns CRC and counter to their start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_ONES;
            r_cnt      <= '0;
            r_hdr_ver  <= '0;
            r_hdr_type <= '0;
            r_hdr_size <= '0;
            r_hdr_chk  <= '0;
        end else if (advance) begin
            r_crc      <= emits ? CRC_ONES : n_crc;
            r_cnt      <= emits ? '0 : n_cnt;
            r_hdr_ver  <= n_hdr_ver;
            r_hdr_type <= n_hdr_type;
            r_hdr_size <= n_hdr_size;
            r_hdr_chk  <= n_hdr_chk;
        end
    end

endmodule

`default_nettype wire

// File: design/mcv_out_stage.sv
// Result register that holds a verdict until the sink takes it.
`default_nettype none

module mcv_out_stage (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire mcv_pkg::t_res i_res,
    input  wire logic     i_ready,
    output logic          o_valid,
    output logic          o_free,
    output mcv_pkg::t_res o_res
);
    import mcv_pkg::*;

    logic r_valid;
    t_res r_res;

    // Free when empty or when the held word goes out this cycle.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: design/message_crc32_validator.sv
// Top level of the streaming message validator with CRC-32 check.
// Each word is captured in the input register, and its verdict is registered in the result register.
// Throughput: one word per cycle; a word that ends a message waits only while the result
// register still holds a verdict that the sink has not taken.
// The CRC-32 byte update and all checks fit between the input and result registers.
// Reset (synchronous, active low) empties both registers, sets the CRC to all ones,
// clears the byte counter and latched header, and restores configuration defaults.
`default_nettype none

module message_crc32_validator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mcv_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [mcv_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mcv_in_if.sink                              i_in,
    mcv_res_if.source                           o_res
);
    import mcv_pkg::*;

    t_cfg     cfg;
    t_in_word in_word;
    t_res     res_next;
    t_res     res_out;
    logic     res_load;
    logic     res_free;
    logic     in_ready;
    logic     out_valid;

    // Gather the input word.
    always_comb begin
        in_word.kind            = i_in.kind;
        in_word.msg_version     = i_in.msg_version;
        in_word.msg_type        = i_in.msg_type;
        in_word.declared_size   = i_in.declared_size;
        in_word.stored_checksum = i_in.stored_checksum;
        in_word.no_payload      = i_in.no_payload;
        in_word.data_byte       = i_in.data_byte;
        in_word.last            = i_in.last;
    end

    assign i_in.ready = in_ready;

    mcv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mcv_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_word     (in_word),
        .i_res_free (res_free),
        .o_res_load (res_load),
        .o_res      (res_next)
    );

    mcv_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res_next),
        .i_ready (o_res.ready),
        .o_valid (out_valid),
        .o_free  (res_free),
        .o_res   (res_out)
    );

    // Drive the result channel.
    assign o_res.valid        = out_valid;
    assign o_res.valid_res    = res_out.valid_res;
    assign o_res.reason_code  = res_out.reason_code;
    assign o_res.checksum_ok  = res_out.checksum_ok;
    assign o_res.computed_crc = res_out.computed_crc;

endmodule

`default_nettype wire

// File: design/mcv_checker.sv
// Port-level assertions for the message validator and their bind.
`default_nettype none

module mcv_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         i_valid_res,
    input wire logic [mcv_pkg::ERR_W-1:0]    i_reason_code,
    input wire logic                         i_checksum_ok,
    input wire logic [mcv_pkg::CRC_W-1:0]    i_computed_crc
);
    import mcv_pkg::*;

    // A stalled verdict word stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_reason_code)
            && $stable(i_valid_res) && $stable(i_checksum_ok) && $stable(i_computed_crc))
        else $error("result word changed while stalled");

    // No verdict is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The pass flag agrees with the reason code.
    a_pass_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_valid_res == (i_reason_code == ERR_OK)))
        else $error("pass flag disagrees with reason code");

    // A CRC mismatch verdict never comes with a passing strict check.
    a_crc_strict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_reason_code == ERR_CRC) |-> !i_checksum_ok)
        else $error("crc mismatch with passing strict check");

endmodule

bind message_crc32_validator mcv_checker u_mcv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_valid_res    (o_res.valid_res),
    .i_reason_code  (o_res.reason_code),
    .i_checksum_ok  (o_res.checksum_ok),
    .i_computed_crc (o_res.computed_crc)
);

`default_nettype wire
